@@ sv/klex_pkg.sv @@
// Shared types, token kind codes and keyword table for the keyword lexer.
// No dependencies; every other file imports this package.
package klex_pkg;

    localparam int MAX_LEXEME = 32;
    localparam int LEN_W      = $clog2(MAX_LEXEME + 1);
    localparam int IDX_W      = $clog2(MAX_LEXEME);
    localparam int KW_COUNT   = 19;

    localparam logic [5:0] K_INT     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_KW0     = 6'd2;
    localparam logic [5:0] K_SEMI    = 6'd21;
    localparam logic [5:0] K_LPAREN  = 6'd22;
    localparam logic [5:0] K_RPAREN  = 6'd23;
    localparam logic [5:0] K_LBRACE  = 6'd24;
    localparam logic [5:0] K_RBRACE  = 6'd25;
    localparam logic [5:0] K_COMMA   = 6'd26;
    localparam logic [5:0] K_PLUS    = 6'd27;
    localparam logic [5:0] K_MINUS   = 6'd28;
    localparam logic [5:0] K_STAR    = 6'd29;
    localparam logic [5:0] K_DIV     = 6'd30;
    localparam logic [5:0] K_AMP     = 6'd31;
    localparam logic [5:0] K_BAR     = 6'd32;
    localparam logic [5:0] K_EQUALS  = 6'd33;
    localparam logic [5:0] K_ASSIGN  = 6'd34;
    localparam logic [5:0] K_LE      = 6'd35;
    localparam logic [5:0] K_LT      = 6'd36;
    localparam logic [5:0] K_GE      = 6'd37;
    localparam logic [5:0] K_GT      = 6'd38;
    localparam logic [5:0] K_INVALID = 6'd39;
    localparam logic [5:0] K_END     = 6'd40;
    localparam logic [5:0] K_BADINT  = 6'd41;

    localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
        "return", "if", "while", "else", "function", "int", "float",
        "setLED", "clearLED", "setCursor", "printLCD", "readKey", "waitKey",
        "playSound", "stopSound", "delay", "asr", "ror", "rrc"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd2, 4'd5, 4'd4, 4'd8, 4'd3, 4'd5,
        4'd6, 4'd8, 4'd9, 4'd8, 4'd7, 4'd7,
        4'd9, 4'd9, 4'd5, 4'd3, 4'd3, 4'd3
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } src_item_t;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] text_char;
        logic       char_valid;
        logic       token_last;
        logic       truncated;
        logic       run_last;
    } tok_item_t;

    typedef enum logic [3:0] {
        M_START, M_WORD, M_INT, M_COMMENT, M_SLASH, M_EQ, M_LT, M_GT, M_HALT
    } lex_mode_t;

    typedef enum logic [1:0] {
        A_NONE, A_APPEND, A_BEGIN, A_CLEAR
    } lex_act_t;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_CHAR, S_TOKA, S_TOKB, S_COMMIT
    } ctrl_state_t;

    // Work planned for one item: lexeme run or single token, then a second token
    typedef struct packed {
        logic       a_run;
        logic       a_tok;
        logic [5:0] a_kind;
        logic       b_tok;
        logic [5:0] b_kind;
        lex_mode_t  mode;
        lex_act_t   act;
        logic [7:0] ch;
    } plan_t;

    typedef struct packed {
        logic latch;
        logic fetch;
        logic load_char;
        logic load_a;
        logic load_b;
        logic commit;
    } klex_cmd_t;

    typedef struct packed {
        logic dec_a_run;
        logic dec_a_tok;
        logic dec_b_tok;
        logic plan_b_tok;
        logic slot_free;
        logic idx_last;
    } klex_status_t;

    typedef struct packed {
        logic       tok;
        logic [5:0] kind;
        lex_mode_t  mode;
        logic       start;
    } sb_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Character of keyword k at position pos, zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [LEN_W-1:0] pos);
        int p;
        int n;
        p = int'(pos);
        n = int'(KW_LEN[k]);
        if (p >= n)
            return 8'd0;
        return KW_TEXT[k][8*(n-1-p) +: 8];
    endfunction

    // Classify a byte seen in start mode
    function automatic sb_result_t start_byte(input logic [7:0] c);
        sb_result_t r;
        r.tok   = 1'b0;
        r.kind  = K_INVALID;
        r.mode  = M_START;
        r.start = 1'b0;
        if (is_space(c)) begin
            r.tok = 1'b0;
        end else if (is_digit(c)) begin
            r.start = 1'b1;
            r.mode  = M_INT;
        end else if (is_alpha(c)) begin
            r.start = 1'b1;
            r.mode  = M_WORD;
        end else begin
            r.tok = 1'b1;
            case (c)
                "/": begin r.tok = 1'b0; r.mode = M_SLASH; end
                "=": begin r.tok = 1'b0; r.mode = M_EQ; end
                "<": begin r.tok = 1'b0; r.mode = M_LT; end
                ">": begin r.tok = 1'b0; r.mode = M_GT; end
                ";": r.kind = K_SEMI;
                "(": r.kind = K_LPAREN;
                ")": r.kind = K_RPAREN;
                "{": r.kind = K_LBRACE;
                "}": r.kind = K_RBRACE;
                ",": r.kind = K_COMMA;
                "+": r.kind = K_PLUS;
                "-": r.kind = K_MINUS;
                "*": r.kind = K_STAR;
                "&": r.kind = K_AMP;
                "|": r.kind = K_BAR;
                default: r.kind = K_INVALID;
            endcase
        end
        return r;
    endfunction

endpackage

@@ sv/klex_ctrl.sv @@
// Sequencer for the keyword lexer: steps through the results of one item.
// Depends on klex_pkg.
module klex_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_ready,
    output klex_pkg::klex_cmd_t    cmd,
    input  klex_pkg::klex_status_t status
);
    import klex_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance through run, first token, second token, commit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        src_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                src_ready = 1'b1;
                if (src_valid)
                begin
                    cmd.latch = 1'b1;
                    if (status.dec_a_run)
                        state_next = S_FETCH;
                    else if (status.dec_a_tok)
                        state_next = S_TOKA;
                    else if (status.dec_b_tok)
                        state_next = S_TOKB;
                    else
                        state_next = S_COMMIT;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_CHAR;
            end
            S_CHAR:
            begin
                if (status.slot_free)
                begin
                    cmd.load_char = 1'b1;
                    if (!status.idx_last)
                        state_next = S_FETCH;
                    else if (status.plan_b_tok)
                        state_next = S_TOKB;
                    else
                        state_next = S_COMMIT;
                end
            end
            S_TOKA:
            begin
                if (status.slot_free)
                begin
                    cmd.load_a = 1'b1;
                    state_next = status.plan_b_tok ? S_TOKB : S_COMMIT;
                end
            end
            S_TOKB:
            begin
                if (status.slot_free)
                begin
                    cmd.load_b = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/klex_datapath.sv @@
// Datapath of the keyword lexer: decode, lexeme buffer, keyword match, output register.
// Depends on klex_pkg.
module klex_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  klex_pkg::src_item_t    src_item,
    input  klex_pkg::klex_cmd_t    cmd,
    output klex_pkg::klex_status_t status,
    output logic                   tok_valid,
    input  logic                   tok_ready,
    output klex_pkg::tok_item_t    tok_item
);
    import klex_pkg::*;

    lex_mode_t             mode_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  ovf_reg;
    logic [KW_COUNT-1:0]   match_reg;
    logic [KW_COUNT-1:0]   match_next;
    plan_t                 plan_reg;
    plan_t                 dec;
    logic [IDX_W-1:0]      idx_reg;
    logic [7:0]            rdata_reg;
    logic [7:0]            lexeme_mem [MAX_LEXEME];
    logic                  out_valid_reg;
    tok_item_t             out_reg;

    logic                  kw_hit;
    logic [5:0]            kw_kind;
    logic                  take_sb;
    sb_result_t            sbr;
    logic                  idx_last;
    logic                  slot_free;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_addr;
    logic [LEN_W-1:0]      match_pos;

    // Keyword hit on the buffered word
    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (match_reg[k] && (LEN_W'(KW_LEN[k]) == len_reg))
            begin
                kw_hit  = 1'b1;
                kw_kind = K_KW0 + 6'(k);
            end
        end
        if (ovf_reg)
            kw_hit = 1'b0;
    end

    // Decode the incoming item against the current mode
    always_comb
    begin
        dec      = '0;
        dec.mode = mode_reg;
        dec.act  = A_NONE;
        dec.ch   = src_item.ch;
        take_sb  = 1'b0;
        sbr      = start_byte(src_item.ch);
        case (mode_reg)
            M_WORD:
            begin
                if (!src_item.is_end && (is_alpha(src_item.ch) || is_digit(src_item.ch)))
                    dec.act = A_APPEND;
                else
                begin
                    if (kw_hit)
                    begin
                        dec.a_tok  = 1'b1;
                        dec.a_kind = kw_kind;
                    end
                    else
                    begin
                        dec.a_run  = 1'b1;
                        dec.a_kind = K_IDENT;
                    end
                    take_sb = 1'b1;
                end
            end
            M_INT:
            begin
                if (!src_item.is_end && is_digit(src_item.ch))
                    dec.act = A_APPEND;
                else if (src_item.is_end || is_space(src_item.ch) || src_item.ch == ";")
                begin
                    dec.a_run  = 1'b1;
                    dec.a_kind = K_INT;
                    take_sb    = 1'b1;
                end
                else
                begin
                    dec.a_tok  = 1'b1;
                    dec.a_kind = K_BADINT;
                    dec.mode   = M_HALT;
                end
            end
            M_COMMENT:
            begin
                if (src_item.is_end || src_item.ch == 8'h0A)
                    dec.mode = M_START;
            end
            M_SLASH:
            begin
                if (!src_item.is_end && src_item.ch == "/")
                    dec.mode = M_COMMENT;
                else
                begin
                    dec.a_tok  = 1'b1;
                    dec.a_kind = K_DIV;
                    take_sb    = 1'b1;
                end
            end
            M_EQ, M_LT, M_GT:
            begin
                dec.a_tok = 1'b1;
                if (!src_item.is_end && src_item.ch == "=")
                begin
                    dec.mode   = M_START;
                    dec.a_kind = (mode_reg == M_EQ) ? K_EQUALS :
                                 (mode_reg == M_LT) ? K_LE : K_GE;
                end
                else
                begin
                    dec.a_kind = (mode_reg == M_EQ) ? K_ASSIGN :
                                 (mode_reg == M_LT) ? K_LT : K_GT;
                    take_sb    = 1'b1;
                end
            end
            M_HALT:
            begin
                dec.mode = M_HALT;
            end
            default:
            begin
                take_sb = 1'b1;
            end
        endcase
        if (take_sb && !src_item.is_end)
        begin
            dec.b_tok  = sbr.tok;
            dec.b_kind = sbr.kind;
            dec.mode   = sbr.mode;
            dec.act    = sbr.start ? A_BEGIN : A_NONE;
        end
        // End item: flush, then end token and clear
        if (src_item.is_end)
        begin
            dec.b_tok  = 1'b1;
            dec.b_kind = K_END;
            dec.mode   = M_START;
            dec.act    = A_CLEAR;
        end
    end

    // Hold the plan of the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            plan_reg <= dec;
    end

    // Next keyword candidates for the character being stored
    always_comb
    begin
        match_pos = (plan_reg.act == A_BEGIN) ? '0 : len_reg;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            match_next[k] = ((plan_reg.act == A_BEGIN) || match_reg[k]) &&
                            (kw_char(k, match_pos) == plan_reg.ch);
        end
    end

    // Apply mode and lexeme updates at commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            match_reg <= '0;
        end
        else if (cmd.commit)
        begin
            mode_reg <= plan_reg.mode;
            case (plan_reg.act)
                A_APPEND:
                begin
                    if (len_reg < LEN_W'(MAX_LEXEME))
                    begin
                        len_reg   <= len_reg + LEN_W'(1);
                        match_reg <= match_next;
                    end
                    else
                        ovf_reg <= 1'b1;
                end
                A_BEGIN:
                begin
                    len_reg   <= LEN_W'(1);
                    ovf_reg   <= 1'b0;
                    match_reg <= match_next;
                end
                A_CLEAR:
                begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                default:
                begin
                    len_reg <= len_reg;
                end
            endcase
        end
    end

    // Lexeme buffer write and registered read
    assign mem_we  = cmd.commit && ((plan_reg.act == A_BEGIN) ||
                     ((plan_reg.act == A_APPEND) && (len_reg < LEN_W'(MAX_LEXEME))));
    assign wr_addr = (plan_reg.act == A_BEGIN) ? '0 : len_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            lexeme_mem[wr_addr] <= plan_reg.ch;
        if (cmd.fetch)
            rdata_reg <= lexeme_mem[idx_reg];
    end

    // Walk the lexeme index during a run
    assign idx_last = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.latch)
            idx_reg <= '0;
        else if (cmd.load_char && !idx_last)
            idx_reg <= idx_reg + IDX_W'(1);
    end

    // Output register
    assign slot_free = !out_valid_reg || tok_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_char || cmd.load_a || cmd.load_b)
            out_valid_reg <= 1'b1;
        else if (tok_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            out_reg.kind       <= plan_reg.a_kind;
            out_reg.text_char  <= rdata_reg;
            out_reg.char_valid <= 1'b1;
            out_reg.token_last <= idx_last;
            out_reg.truncated  <= ovf_reg;
            out_reg.run_last   <= idx_last && !plan_reg.b_tok;
        end
        else if (cmd.load_a)
        begin
            out_reg.kind       <= plan_reg.a_kind;
            out_reg.text_char  <= 8'd0;
            out_reg.char_valid <= 1'b0;
            out_reg.token_last <= 1'b1;
            out_reg.truncated  <= 1'b0;
            out_reg.run_last   <= !plan_reg.b_tok;
        end
        else if (cmd.load_b)
        begin
            out_reg.kind       <= plan_reg.b_kind;
            out_reg.text_char  <= 8'd0;
            out_reg.char_valid <= 1'b0;
            out_reg.token_last <= 1'b1;
            out_reg.truncated  <= 1'b0;
            out_reg.run_last   <= 1'b1;
        end
    end

    assign tok_valid = out_valid_reg;
    assign tok_item  = out_reg;

    assign status.dec_a_run  = dec.a_run;
    assign status.dec_a_tok  = dec.a_tok;
    assign status.dec_b_tok  = dec.b_tok;
    assign status.plan_b_tok = plan_reg.b_tok;
    assign status.slot_free  = slot_free;
    assign status.idx_last   = idx_last;

endmodule

@@ sv/keyword_lexer_stream.sv @@
// Top level of the streaming keyword lexer: sequencer plus datapath.
// Depends on klex_pkg, klex_ctrl and klex_datapath.
//
// Takes one source byte (or an end marker) per item and emits tokens. An item
// that yields no token passes through accept, then commit of the lexeme
// update; each single token adds a load step, and a streamed identifier or
// integer adds, for each character, the registered read of the lexeme buffer
// followed by the load of the output register. Results wait in an output
// register, so a stalled consumer only holds the sequencer.
module keyword_lexer_stream (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_ready,
    input  klex_pkg::src_item_t src_item,
    output logic                tok_valid,
    input  logic                tok_ready,
    output klex_pkg::tok_item_t tok_item
);
    import klex_pkg::*;

    klex_cmd_t    cmd;
    klex_status_t status;

    klex_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .cmd       (cmd),
        .status    (status)
    );

    klex_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_item  (src_item),
        .cmd       (cmd),
        .status    (status),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    // Characters only travel on identifier and integer tokens
    a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.char_valid |-> tok_item.kind == K_INT || tok_item.kind == K_IDENT)
        else $error("lexeme character on non-lexeme token");

    // The last result of an item closes its token
    a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.run_last |-> tok_item.token_last)
        else $error("run_last without token_last");

    // Truncation flag only on character results
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_item.truncated |-> tok_item.char_valid)
        else $error("truncated flag on token without characters");

    // No new item while results are being produced
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_ready |=> !src_ready)
        else $error("item accepted back to back");

endmodule
